### src/lkc_pkg.sv
// ----------------------------------------------------------------------------
// lkc_pkg: shared types and codes of the LRU key cache directory
// Widths, status and update codes, and the structs that pass along and
// across the row of directory cells.
// ----------------------------------------------------------------------------
package lkc_pkg;

  // Default directory depth
  localparam int unsigned LKC_ENTRIES = 16;
  // Index and rank width, sized for the largest supported depth (256)
  localparam int unsigned LKC_IDX_W   = 8;
  // Entry count width (0 .. 256)
  localparam int unsigned LKC_CNT_W   = LKC_IDX_W + 1;
  // Key is {frame, field}
  localparam int unsigned LKC_FRAME_W = 16;
  localparam int unsigned LKC_FIELD_W = 4;
  localparam int unsigned LKC_KEY_W   = LKC_FRAME_W + LKC_FIELD_W;

  // Result status codes
  localparam logic [1:0] ST_HIT    = 2'd0;
  localparam logic [1:0] ST_INSERT = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;
  localparam logic [1:0] ST_NOLOAD = 2'd3;

  // Cell update operations
  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_HIT    = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;
  localparam logic [1:0] OP_INSERT = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_FRAMES = 2'd1;
  localparam logic [1:0] REG_FIELDS = 2'd2;

  // Per-item lookup context, broadcast to every cell while an item is in flight
  typedef struct packed {
    logic [LKC_KEY_W-1:0] key;      // requested key
    logic                 zero_w;   // window is zero: flush mode
    logic                 ev_on;    // window full: evict least recent
    logic [LKC_IDX_W-1:0] ev_rank;  // rank of the least recent entry
  } lkc_scan_t;

  // Scan token, handed from cell to cell once per cycle
  typedef struct packed {
    logic                 vld;
    logic                 hit;
    logic [LKC_IDX_W-1:0] hit_idx;
    logic [LKC_IDX_W-1:0] hit_rank;
    logic                 ev;
    logic [LKC_KEY_W-1:0] ev_key;
    logic                 free;
    logic [LKC_IDX_W-1:0] free_idx;
  } lkc_token_t;

  // State update command, broadcast to every cell
  typedef struct packed {
    logic [1:0]           op;
    logic [LKC_IDX_W-1:0] idx;      // hit entry or placement entry
    logic [LKC_IDX_W-1:0] rank;     // rank of the hit entry
    logic                 trim_en;  // window write: drop ranks >= trim_w
    logic [LKC_CNT_W-1:0] trim_w;
  } lkc_upd_t;

endpackage

### src/lkc_cell.sv
// ----------------------------------------------------------------------------
// lkc_cell: one directory entry
// Holds key, valid, live and recency rank of one entry, folds its own
// match, eviction and free-entry status into the passing scan token, and
// applies broadcast update commands.
// ----------------------------------------------------------------------------
module lkc_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lkc_pkg::lkc_scan_t  ctl_i,
  input  lkc_pkg::lkc_upd_t   upd_i,
  input  lkc_pkg::lkc_token_t tok_i,
  output lkc_pkg::lkc_token_t tok_o
);
  import lkc_pkg::*;

  localparam logic [LKC_IDX_W-1:0] MyIdx = LKC_IDX_W'(INDEX);

  logic                 valid_q, valid_d;
  logic                 live_q, live_d;
  logic [LKC_IDX_W-1:0] rank_q, rank_d;
  logic [LKC_KEY_W-1:0] key_q, key_d;
  lkc_token_t           tok_q, tok_d;

  logic match, is_lru, ev_cand, free_cand, self_sel;

  // Local status of this entry for the current item
  assign match     = valid_q && live_q && (key_q == ctl_i.key);
  assign is_lru    = valid_q && ctl_i.ev_on && (rank_q == ctl_i.ev_rank);
  assign ev_cand   = ctl_i.zero_w ? valid_q : is_lru;
  assign free_cand = !valid_q || is_lru;
  assign self_sel  = (upd_i.idx == MyIdx);

  // Fold into the token: lowest index wins for each search
  always_comb begin
    tok_d = tok_i;
    if (!tok_i.hit && match) begin
      tok_d.hit      = 1'b1;
      tok_d.hit_idx  = MyIdx;
      tok_d.hit_rank = rank_q;
    end
    if (!tok_i.ev && ev_cand) begin
      tok_d.ev     = 1'b1;
      tok_d.ev_key = key_q;
    end
    if (!tok_i.free && free_cand) begin
      tok_d.free     = 1'b1;
      tok_d.free_idx = MyIdx;
    end
  end

  // Entry update
  always_comb begin
    valid_d = valid_q;
    live_d  = live_q;
    rank_d  = rank_q;
    key_d   = key_q;
    case (upd_i.op)
      OP_HIT: begin
        if (valid_q && (rank_q < upd_i.rank)) rank_d = rank_q + 1'b1;
        if (self_sel) rank_d = '0;
      end
      OP_FLUSH: begin
        valid_d = 1'b0;
        live_d  = 1'b0;
        // transient entry that can never hit
        if (INDEX == 0) begin
          valid_d = 1'b1;
          rank_d  = '0;
          key_d   = ctl_i.key;
        end
      end
      OP_INSERT: begin
        if (is_lru) begin
          valid_d = 1'b0;
          live_d  = 1'b0;
        end else if (valid_q) begin
          rank_d = rank_q + 1'b1;
        end
        if (self_sel) begin
          valid_d = 1'b1;
          live_d  = 1'b1;
          rank_d  = '0;
          key_d   = ctl_i.key;
        end
      end
      default: begin
      end
    endcase
    // window lowered: drop entries beyond it
    if (upd_i.trim_en && valid_q && (LKC_CNT_W'(rank_q) >= upd_i.trim_w)) begin
      valid_d = 1'b0;
      live_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      live_q  <= 1'b0;
      rank_q  <= '0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      live_q  <= live_d;
      rank_q  <= rank_d;
      tok_q   <= tok_d;
    end
  end

  // key storage, meaningful only while valid
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign tok_o = tok_q;

endmodule

### src/lru_key_cache_directory_unit.sv
// ----------------------------------------------------------------------------
// lru_key_cache_directory_unit: fully associative LRU key directory
// A row of ENTRIES cells holds the keys; a scan token walks the row and the
// outcome is applied to all cells at once.
// ----------------------------------------------------------------------------
// Usage:
//   An item (frame_number_i, field_number_i, data_available_i) is taken at
//   a rising edge with start_i high and busy_o low. busy_o stays high until
//   the result has been produced.
//   The result (status, slot, evicted key, occupancy) is marked valid by
//   done_o, high for a single cycle; the receiver cannot stall.
//   The accepting edge launches the scan token, which moves one cell per
//   cycle along the cell row; when it leaves the last cell, the outcome is
//   applied to all cells and the result is registered with done_o.
//   One item is handled at a time.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i;
//   write only while idle, which the block does not enforce. A window
//   write trims the least recent entries beyond the new window at that edge.
//   Reset: directory empty, window 16, frame and field limits 0
//   (every lookup reports out of range until the limits are written).
// ----------------------------------------------------------------------------
module lru_key_cache_directory_unit #(
  parameter int unsigned ENTRIES = lkc_pkg::LKC_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] frame_number_i,
  input  logic [3:0]  field_number_i,
  input  logic        data_available_i,
  // result channel
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [3:0]  slot_o,
  output logic        evicted_valid_o,
  output logic [15:0] evicted_frame_o,
  output logic [3:0]  evicted_field_o,
  output logic [4:0]  occupancy_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [16:0] cfg_wdata_i
);
  import lkc_pkg::*;

  // configuration registers
  logic [4:0]  window_q;
  logic [16:0] frames_q;
  logic [4:0]  fields_q;

  // control
  logic                 busy_q;
  logic [LKC_CNT_W-1:0] held_q, held_d;
  lkc_token_t           tok0_q, tok0_d;

  // per-item context
  lkc_scan_t ctl_q;
  logic      avail_q, oor_q;

  // result registers
  logic                 done_q;
  logic [1:0]           status_q, status_d;
  logic [LKC_IDX_W-1:0] slot_q, slot_d;
  logic                 evv_q, evv_d;
  logic [LKC_KEY_W-1:0] evk_q, evk_d;

  logic                 accept;
  logic [LKC_CNT_W-1:0] w_eff, w_new;
  lkc_token_t           tok_w [ENTRIES+1];
  lkc_token_t           tok_last;
  lkc_upd_t             upd;

  assign accept = start_i && !busy_q;

  // Effective window, saturated to the depth
  assign w_eff = (32'(window_q) > ENTRIES) ? LKC_CNT_W'(ENTRIES)
                                            : LKC_CNT_W'(window_q);
  assign w_new = (32'(cfg_wdata_i[4:0]) > ENTRIES) ? LKC_CNT_W'(ENTRIES)
                                                    : LKC_CNT_W'(cfg_wdata_i[4:0]);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= 5'd16;
      frames_q <= '0;
      fields_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW: window_q <= cfg_wdata_i[4:0];
        REG_FRAMES: frames_q <= cfg_wdata_i;
        REG_FIELDS: fields_q <= cfg_wdata_i[4:0];
        default: begin
        end
      endcase
    end
  end

  // Item capture: key, range check and eviction plan
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctl_q.key     <= {frame_number_i, field_number_i};
      ctl_q.zero_w  <= (w_eff == '0);
      ctl_q.ev_on   <= (w_eff != '0) && (held_q >= w_eff);
      ctl_q.ev_rank <= LKC_IDX_W'(held_q - 1'b1);
      avail_q       <= data_available_i;
      oor_q         <= ({1'b0, frame_number_i} >= frames_q) ||
                       ({1'b0, field_number_i} >= fields_q);
    end
  end

  // Fresh token, empty apart from its valid bit
  always_comb begin
    tok0_d     = '0;
    tok0_d.vld = accept;
  end

  // Token launch and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      tok0_q <= '0;
    end else begin
      tok0_q <= tok0_d;
      if (accept) busy_q <= 1'b1;
      else if (tok_last.vld) busy_q <= 1'b0;
    end
  end

  // Cell row
  assign tok_w[0] = tok0_q;
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkc_cell #(
      .INDEX(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl_q),
      .upd_i (upd),
      .tok_i (tok_w[g]),
      .tok_o (tok_w[g+1])
    );
  end
  assign tok_last = tok_w[ENTRIES];

  // Outcome of a finished scan, and window trims
  always_comb begin
    status_d = ST_RANGE;
    slot_d   = '0;
    evv_d    = 1'b0;
    evk_d    = '0;
    held_d   = held_q;
    upd      = '0;
    upd.op   = OP_NONE;
    if (tok_last.vld) begin
      if (oor_q) begin
        status_d = ST_RANGE;
      end else if (tok_last.hit) begin
        status_d = ST_HIT;
        slot_d   = tok_last.hit_idx;
        upd.op   = OP_HIT;
        upd.idx  = tok_last.hit_idx;
        upd.rank = tok_last.hit_rank;
      end else if (!avail_q) begin
        status_d = ST_NOLOAD;
      end else if (ctl_q.zero_w) begin
        // flush, keep the new key as a transient entry
        status_d = ST_INSERT;
        evv_d    = tok_last.ev;
        evk_d    = tok_last.ev ? tok_last.ev_key : '0;
        held_d   = LKC_CNT_W'(1);
        upd.op   = OP_FLUSH;
      end else begin
        status_d = ST_INSERT;
        slot_d   = tok_last.free_idx;
        evv_d    = ctl_q.ev_on;
        evk_d    = ctl_q.ev_on ? tok_last.ev_key : '0;
        held_d   = held_q + LKC_CNT_W'(1) - LKC_CNT_W'(ctl_q.ev_on);
        upd.op   = OP_INSERT;
        upd.idx  = tok_last.free_idx;
      end
    end
    if (cfg_we_i && (cfg_idx_i == REG_WINDOW)) begin
      upd.trim_en = 1'b1;
      upd.trim_w  = w_new;
      if (held_q > w_new) held_d = w_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      done_q <= 1'b0;
    end else begin
      held_q <= held_d;
      done_q <= tok_last.vld;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (tok_last.vld) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      evv_q    <= evv_d;
      evk_q    <= evk_d;
    end
  end

  assign busy_o          = busy_q;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign slot_o          = slot_q[3:0];
  assign evicted_valid_o = evv_q;
  assign evicted_frame_o = evk_q[LKC_KEY_W-1:LKC_FIELD_W];
  assign evicted_field_o = evk_q[LKC_FIELD_W-1:0];
  assign occupancy_o     = held_q[4:0];

  // Checks
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(held_q) <= ENTRIES)
    else $error("entry count beyond directory depth");

  a_scan_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_last.vld |-> busy_q)
    else $error("scan token finished with no item in flight");

  a_done_follows_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_last.vld |=> done_q && !busy_q)
    else $error("result not delivered after scan");

  a_insert_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (status_q == ST_INSERT) |-> held_q != '0)
    else $error("insert left directory empty");

endmodule
